>>> design/hks_pkg.sv
// shared types, constants and helpers for the hight key schedule
package hks_pkg;

	localparam int KeyW       = 64;
	localparam int WordIdxW   = 5;
	localparam int LastWord   = 16;
	localparam int BytesPerW  = 8;
	localparam int LfsrW      = 7;
	localparam int QueueDepth = 2;

	localparam logic [LfsrW-1:0] LfsrSeed = 7'h5A;

	typedef struct packed {
		logic [KeyW-1:0] key_high;
		logic [KeyW-1:0] key_low;
	} key_item_t;

	// one step of the delta generator: s[n+7] = s[n+3] ^ s[n]
	function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] s);
		return {s[3] ^ s[0], s[LfsrW-1:1]};
	endfunction

endpackage

>>> design/hks_key_queue.sv
// front part: small queue of master keys waiting for expansion
module hks_key_queue #(
	parameter int Depth = hks_pkg::QueueDepth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [hks_pkg::KeyW-1:0] key_low,
	input  logic [hks_pkg::KeyW-1:0] key_high,
	output logic                    head_valid,
	output hks_pkg::key_item_t      head,
	input  logic                    take
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	hks_pkg::key_item_t slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic wr_en;
	logic rd_en;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = take && head_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= '{key_high: key_high, key_low: key_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/hks_word_gen.sv
// back part: expands one key into seventeen words, one per cycle while pop keeps up, into an output register
module hks_word_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  hks_pkg::key_item_t          head,
	output logic                        take,
	output logic                        empty,
	input  logic                        pop,
	output logic [hks_pkg::WordIdxW-1:0] word_index,
	output logic [hks_pkg::KeyW-1:0]     round_key_word,
	output logic                        last_word
);

	localparam int BW = hks_pkg::BytesPerW;

	logic [2*hks_pkg::KeyW-1:0]    key_q;
	logic [hks_pkg::WordIdxW-1:0]  word_q;
	logic [hks_pkg::LfsrW-1:0]     lfsr_q;
	logic                          busy_q;
	logic                          out_v_q;
	logic [hks_pkg::WordIdxW-1:0]  word_index_q;
	logic [hks_pkg::KeyW-1:0]      round_key_word_q;
	logic                          last_word_q;

	logic                          emit;
	logic                          at_last;
	logic [hks_pkg::WordIdxW-1:0]  wm1;
	logic [2:0]                    row;
	logic                          half;
	logic [hks_pkg::LfsrW-1:0]     dlt [BW+1];
	logic [hks_pkg::KeyW-1:0]      word_val;

	assign emit    = busy_q && (!out_v_q || pop);
	assign at_last = (word_q == hks_pkg::WordIdxW'(hks_pkg::LastWord));
	assign take    = head_valid && (!busy_q || (emit && at_last));
	assign wm1     = word_q - 1'b1;
	assign row     = wm1[3:1];
	assign half    = wm1[0];

	always_comb begin
		logic [2:0] rot;
		rot      = '0;
		dlt[0]   = lfsr_q;
		word_val = '0;
		for (int n = 0; n < BW; n++) begin
			dlt[n+1] = hks_pkg::lfsr_next(dlt[n]);
		end
		if (word_q == '0) begin
			// whitening keys: bytes 12..15 then 0..3
			word_val = {key_q[31:0], key_q[127:96]};
		end else begin
			for (int n = 0; n < BW; n++) begin
				rot = 3'(n) - row;
				word_val[8*n +: 8] = key_q[8*{half, rot} +: 8] + {1'b0, dlt[n]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= {head.key_high, head.key_low};
		end
		if (emit) begin
			word_index_q     <= word_q;
			round_key_word_q <= word_val;
			last_word_q      <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			word_q  <= '0;
			lfsr_q  <= hks_pkg::LfsrSeed;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				word_q <= '0;
				lfsr_q <= hks_pkg::LfsrSeed;
			end else if (emit) begin
				word_q <= word_q + 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
				// the whitening word uses no deltas
				if (word_q != '0) begin
					lfsr_q <= dlt[BW];
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty          = !out_v_q;
	assign word_index     = word_index_q;
	assign round_key_word = round_key_word_q;
	assign last_word      = last_word_q;

endmodule

>>> design/hight_key_schedule.sv
// top level of the hight key schedule: key queue feeding the word generator
//
// channel   handshake        payload
// key in    push / full      key_low, key_high
// words out pop / empty      word_index, round_key_word, last_word
//
// each key gives 17 words, one per cycle while pop keeps up;
// the next key is loaded on the last word
// keys queue up to QueueDepth deep while the generator works
// a stalled pop holds the output register and freezes the generator
// arst_n clears queue pointers, generator state and the output valid flag
module hight_key_schedule #(
	parameter int QueueDepth = hks_pkg::QueueDepth
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [hks_pkg::KeyW-1:0]     key_low,
	input  logic [hks_pkg::KeyW-1:0]     key_high,
	output logic                        empty,
	input  logic                        pop,
	output logic [hks_pkg::WordIdxW-1:0] word_index,
	output logic [hks_pkg::KeyW-1:0]     round_key_word,
	output logic                        last_word
);

	logic               head_valid;
	hks_pkg::key_item_t head;
	logic               take;

	hks_key_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.key_low   (key_low),
		.key_high  (key_high),
		.head_valid(head_valid),
		.head      (head),
		.take      (take)
	);

	hks_word_gen u_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.take          (take),
		.empty         (empty),
		.pop           (pop),
		.word_index    (word_index),
		.round_key_word(round_key_word),
		.last_word     (last_word)
	);

endmodule

>>> bench/tb_hight_key_schedule.sv
// self-checking testbench for the hight key schedule: keys in, 17 predicted words out
`timescale 1ns / 1ps

module tb_hight_key_schedule;

	localparam int ClkPeriod    = 12;
	localparam int WordsPerKey  = hks_pkg::LastWord + 1;
	localparam int MaxIdle      = 13;
	localparam int StallLimit   = 2000;
	localparam int SettleCycles = 40;

	typedef struct {
		logic [hks_pkg::WordIdxW-1:0] idx;
		logic [hks_pkg::KeyW-1:0]     word;
		logic                         last;
	} key_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic [hks_pkg::KeyW-1:0]     key_low;
	logic [hks_pkg::KeyW-1:0]     key_high;
	logic                         empty;
	logic                         pop;
	logic [hks_pkg::WordIdxW-1:0] word_index;
	logic [hks_pkg::KeyW-1:0]     round_key_word;
	logic                         last_word;

	key_word_t expected_words[$];
	int        mismatch_count = 0;
	int        pop_hold = 0;
	int        stall_cycles = 0;
	bit        no_idle = 0;

	hight_key_schedule u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.key_low        (key_low),
		.key_high       (key_high),
		.empty          (empty),
		.pop            (pop),
		.word_index     (word_index),
		.round_key_word (round_key_word),
		.last_word      (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(0, MaxIdle);
	endfunction

	// expands one master key into whitening word and sixteen subkey words
	function automatic void expand_key(input logic [hks_pkg::KeyW-1:0] lo,
		input logic [hks_pkg::KeyW-1:0] hi);
		logic [7:0]                kb[16];
		logic [7:0]                delta[128];
		logic [7:0]                sk[128];
		logic [hks_pkg::LfsrW-1:0] s;
		logic                      fb;
		int                        r;
		key_word_t                 w;
		for (int b = 0; b < 8; b++) begin
			kb[b]     = lo[8*b +: 8];
			kb[b + 8] = hi[8*b +: 8];
		end
		s = hks_pkg::LfsrSeed;
		for (int n = 0; n < 128; n++) begin
			delta[n] = {1'b0, s};
			fb = s[3] ^ s[0];
			s = {fb, s[hks_pkg::LfsrW-1:1]};
		end
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++) begin
				r = (j - i + 8) % 8;
				sk[16*i + j]     = kb[r] + delta[16*i + j];
				sk[16*i + j + 8] = kb[r + 8] + delta[16*i + j + 8];
			end
		end
		w.idx  = '0;
		w.last = 1'b0;
		for (int n = 0; n < 8; n++)
			w.word[8*n +: 8] = (n < 4) ? kb[12 + n] : kb[n - 4];
		expected_words.push_back(w);
		for (int k = 1; k < WordsPerKey; k++) begin
			w.idx  = k[hks_pkg::WordIdxW-1:0];
			w.last = (k == hks_pkg::LastWord);
			for (int n = 0; n < 8; n++)
				w.word[8*n +: 8] = sk[8*(k - 1) + n];
			expected_words.push_back(w);
		end
	endfunction

	// bytes biased toward 00 and ff so the delta additions wrap often
	function automatic logic [hks_pkg::KeyW-1:0] rand_key_half();
		logic [hks_pkg::KeyW-1:0] v;
		for (int b = 0; b < 8; b++) begin
			case ($urandom_range(0, 5))
				0: v[8*b +: 8] = 8'h00;
				1: v[8*b +: 8] = 8'hFF;
				default: v[8*b +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return v;
	endfunction

	task automatic send_key(input logic [hks_pkg::KeyW-1:0] lo,
		input logic [hks_pkg::KeyW-1:0] hi);
		int gap;
		gap = draw_idle();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push     <= 1'b1;
		key_low  <= lo;
		key_high <= hi;
		do @(posedge clk); while (full);
		expand_key(lo, hi);
	endtask

	task automatic release_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic test_directed_keys();
		logic [hks_pkg::KeyW-1:0] walk;
		send_key('0, '0);
		send_key('1, '1);
		send_key({8{8'hAA}}, {8{8'h55}});
		send_key({8{8'h55}}, {8{8'hAA}});
		send_key(64'h0706050403020100, 64'h0F0E0D0C0B0A0908);
		send_key(64'h8899AABBCCDDEEFF, 64'h0011223344556677);
		send_key({8{8'h80}}, {8{8'h7F}});
		for (int b = 0; b < 16; b += 3) begin
			walk = 64'h1 << (8*(b % 8) + b % 8);
			if (b < 8)
				send_key(walk, ~walk);
			else
				send_key(~walk, walk);
		end
		release_push();
	endtask

	// both sides run flat out so the key queue fills and full rises
	task automatic test_back_to_back();
		no_idle = 1;
		for (int n = 0; n < 30; n++)
			send_key({$urandom, $urandom}, {$urandom, $urandom});
		release_push();
		no_idle = 0;
	endtask

	// sender waits for every word to drain after each burst
	task automatic test_drain_pause();
		for (int burst = 0; burst < 5; burst++) begin
			for (int n = 0; n < 4; n++)
				send_key(rand_key_half(), rand_key_half());
			release_push();
			while (expected_words.size() != 0) @(posedge clk);
		end
	endtask

	task automatic test_random_keys();
		for (int n = 0; n < 360; n++) begin
			if (n % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				send_key({$urandom, $urandom}, {$urandom, $urandom});
			else
				send_key(rand_key_half(), rand_key_half());
		end
		release_push();
		no_idle = 0;
	endtask

	initial begin
		arst_n   = 1'b0;
		push     = 1'b0;
		key_low  = '0;
		key_high = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_keys();
		test_back_to_back();
		test_drain_pause();
		test_random_keys();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("hight_key_schedule regression: pass");
		else
			$display("hight_key_schedule regression: fail");
		$finish;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_words
		key_word_t exp_w;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected word: expected none, actual index %0d word %h",
					$time, word_index, round_key_word);
			end else begin
				exp_w = expected_words.pop_front();
				if (word_index !== exp_w.idx) begin
					mismatch_count++;
					$display("%0t word_index: expected %0d, actual %0d",
						$time, exp_w.idx, word_index);
				end
				if (round_key_word !== exp_w.word) begin
					mismatch_count++;
					$display("%0t round_key_word (index %0d): expected %h, actual %h",
						$time, exp_w.idx, exp_w.word, round_key_word);
				end
				if (last_word !== exp_w.last) begin
					mismatch_count++;
					$display("%0t last_word (index %0d): expected %b, actual %b",
						$time, exp_w.idx, exp_w.last, last_word);
				end
			end
			pop_hold = draw_idle();
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= StallLimit) begin
			$display("hight_key_schedule regression: fail");
			$finish;
		end
	end

endmodule

>>> hight_key_schedule.f
design/hks_pkg.sv
design/hks_key_queue.sv
design/hks_word_gen.sv
design/hight_key_schedule.sv
bench/tb_hight_key_schedule.sv
